// File: sv/damm_check_digit_macros.svh
// Assertion macros for the Damm check digit block.
// The clocked form samples on clock and is switched off while reset is high.
`ifndef DAMM_CHECK_DIGIT_MACROS_SVH
`define DAMM_CHECK_DIGIT_MACROS_SVH
`ifndef ASSERT_OFF
`define DCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DCD_ASSERT(label, prop, msg)
`define DCD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: sv/dcd_pkg.sv
package dcd_pkg;

   // Decimal digits walked for one input number.
   localparam int DECIMAL_DIGITS = 10;
   localparam int BIN_WIDTH      = 32;
   localparam int DIGIT_WIDTH    = 4;
   localparam int BCD_WIDTH      = DECIMAL_DIGITS * DIGIT_WIDTH;
   localparam int CNT_WIDTH      =
      $clog2((BIN_WIDTH > DECIMAL_DIGITS) ? BIN_WIDTH : DECIMAL_DIGITS);

   // Control from the sequencer to the datapath units.
   typedef struct packed {
      logic load;
      logic dabble;
      logic shift_digit;
   } dcd_ctrl_type;

   localparam logic [3:0] QUASIGROUP [10][10] = '{
      '{4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2},
      '{4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3},
      '{4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9},
      '{4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6},
      '{4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8},
      '{4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1},
      '{4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4},
      '{4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7},
      '{4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5},
      '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0}
   };

   // One fold of the accumulator through the quasigroup table.
   function automatic logic [3:0] damm_step(logic [3:0] acc, logic [3:0] digit);
      logic [3:0] result;
      result = 4'd0;
      if ((acc <= 4'd9) && (digit <= 4'd9)) begin
         result = QUASIGROUP[acc][digit];
      end
      return result;
   endfunction

endpackage

// File: sv/dcd_convert.sv
module dcd_convert (
   input  logic                           clock,
   input  dcd_pkg::dcd_ctrl_type          ctrl,
   input  logic [dcd_pkg::BIN_WIDTH-1:0]  value,
   output logic [dcd_pkg::DIGIT_WIDTH-1:0] digit
);
   import dcd_pkg::*;

   logic [BIN_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0] adjusted;

   // Each BCD digit of five or more gets three added before the shift.
   always_comb begin
      adjusted = bcd_ff;
      for (int i = 0; i < DECIMAL_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= 4'd5) begin
            adjusted[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      priority if (ctrl.load) begin
         bin_in = value;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = bin_ff << 1;
         bcd_in = (adjusted << 1) | BCD_WIDTH'(bin_ff[BIN_WIDTH-1]);
      end else if (ctrl.shift_digit) begin
         bcd_in = bcd_ff << DIGIT_WIDTH;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   // Most significant digit first.
   assign digit = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];

endmodule

// File: sv/dcd_fold.sv
module dcd_fold (
   input  logic                            clock,
   input  dcd_pkg::dcd_ctrl_type           ctrl,
   input  logic [dcd_pkg::DIGIT_WIDTH-1:0] digit,
   output logic [3:0]                      check_digit
);
   import dcd_pkg::*;

   logic [3:0] acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      priority if (ctrl.load) begin
         acc_in = 4'd0;
      end else if (ctrl.shift_digit) begin
         acc_in = damm_step(acc_ff, digit);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign check_digit = acc_ff;

endmodule

// File: sv/damm_check_digit.sv
// Channel   Direction  Ports                          Word
// req       in         req_valid/req_ready            req_value, 32-bit unsigned number
// rsp       out        rsp_valid/rsp_ready            rsp_check_digit, 0 to 9
//
// The accepting edge loads a word, then 32 shift-add-3 steps and 10 table
// folds run, and the result fills the output register. req_ready is high only
// while the sequencer is idle, so a new word can start only once the last has
// gone to the output register. Reset is synchronous, active high, and clears
// the sequencer and the output valid flag. A stalled result holds in the output
// register while the next word runs; its last step waits for the slot.
`include "damm_check_digit_macros.svh"

module damm_check_digit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_check_digit
);
   import dcd_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_FOLD = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] step_cnt_ff, step_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           rsp_digit_ff, rsp_digit_in;

   dcd_ctrl_type         ctrl;
   logic [DIGIT_WIDTH-1:0] digit;
   logic [3:0]           fold_result;
   logic                 accept;
   logic                 out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The converter and the fold unit are both driven from here.
   always_comb begin
      ctrl.load        = accept;
      ctrl.dabble      = (state_ff == ST_CONV);
      ctrl.shift_digit = (state_ff == ST_FOLD);
   end

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_CONV;
               step_cnt_in = '0;
            end
         end
         ST_CONV: begin
            if (step_cnt_ff == CNT_WIDTH'(BIN_WIDTH - 1)) begin
               state_in    = ST_FOLD;
               step_cnt_in = '0;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_FOLD: begin
            if (step_cnt_ff == CNT_WIDTH'(DECIMAL_DIGITS - 1)) begin
               state_in    = ST_FIN;
               step_cnt_in = '0;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register takes the fold result once the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_digit_in = rsp_digit_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_FIN) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_digit_in = fold_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_digit_ff <= rsp_digit_in;
   end

   dcd_convert u_convert (
      .clock (clock),
      .ctrl  (ctrl),
      .value (req_value),
      .digit (digit)
   );

   dcd_fold u_fold (
      .clock       (clock),
      .ctrl        (ctrl),
      .digit       (digit),
      .check_digit (fold_result)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_check_digit = rsp_digit_ff;

   // An accepted word starts the converter at its first bit.
   `DCD_ASSERT(a_accept_starts_conv, accept |=> (state_ff == ST_CONV) && (step_cnt_ff == '0), "accepted word did not start conversion")
   // A result is only ever published from the final state.
   `DCD_ASSERT(a_rsp_from_fin, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN), "result appeared outside the final state")
   // A finished word with a free slot is published and the block goes idle.
   `DCD_ASSERT(a_fin_publishes, (state_ff == ST_FIN) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE), "finished word was not published")
   // A published check digit is always a decimal digit.
   `DCD_ASSERT_ALWAYS(a_digit_range, rsp_valid_ff |-> (rsp_digit_ff <= 4'd9), "check digit out of range")

endmodule

// File: test/damm_check_digit_checker.sv
module damm_check_digit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_check_digit,
   output int          fail_count,
   output int          pending,
   output int          words_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUMBER_DIGITS = 10;

   // Weakly totally anti-symmetric quasigroup, indexed [accumulator][digit].
   localparam logic [3:0] DAMM_TABLE [10][10] = '{
      '{4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2},
      '{4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3},
      '{4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9},
      '{4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6},
      '{4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8},
      '{4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1},
      '{4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4},
      '{4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7},
      '{4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5},
      '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0}
   };

   logic [3:0]  digits_expected [$];
   logic [31:0] values_pending  [$];

   // Splits the number into decimal digits and folds them, most significant
   // first, starting from an accumulator of zero.
   function automatic logic [3:0] damm_digit_of(input logic [31:0] number);
      logic [31:0] rest;
      logic [3:0]  decimal [NUMBER_DIGITS];
      logic [3:0]  acc;
      rest = number;
      acc  = 4'd0;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         decimal[i] = 4'(rest % 32'd10);
         rest       = rest / 32'd10;
      end
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
         acc = DAMM_TABLE[acc][decimal[i]];
      end
      return acc;
   endfunction

   initial begin
      fail_count    = 0;
      pending       = 0;
      words_checked = 0;
   end

   always @(posedge clock) begin
      logic [3:0]  want;
      logic [31:0] source;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (digits_expected.size() == 0) begin
               $error("check_digit %0d arrived with no word outstanding", rsp_check_digit);
               fail_count++;
            end else begin
               want   = digits_expected.pop_front();
               source = values_pending.pop_front();
               words_checked++;
               if (rsp_check_digit !== want) begin
                  $error("check_digit mismatch for value %0d: expected %0d, actual %0d",
                         source, want, rsp_check_digit);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            digits_expected.push_back(damm_digit_of(req_value));
            values_pending.push_back(req_value);
         end
         pending = digits_expected.size();
      end
   end

endmodule

// File: test/tb_damm_check_digit.sv
module tb_damm_check_digit;

   timeunit 1ns;
   timeprecision 1ps;

   // Random words after the directed list, and how many of the last ones run
   // with neither sender gaps nor receiver stalls.
   localparam int RANDOM_WORDS = 1830;
   localparam int CALM_WORDS   = 150;
   // The drain wait adds some margin after the last result.
   localparam int DRAIN_CYCLES = 64;
   // The slowest legal run, near 1850 words with sender gaps and receiver stalls,
   // stays far below this bound, so it leaves a wide margin.
   localparam int LIMIT_CYCLES = 1000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_check_digit;

   int fail_count;
   int pending;
   int words_checked;

   // Set at each rising edge to whether a word was accepted there; the
   // stimulus reads it at the following falling edge, so it never races the
   // block's own updates.
   logic req_taken;
   // Turns off all idling for the closing stretch of the run.
   logic calm;
   int   cycle_count;
   int   directed_sent;
   int   random_sent;

   damm_check_digit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_check_digit (rsp_check_digit)
   );

   damm_check_digit_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_check_digit (rsp_check_digit),
      .fail_count      (fail_count),
      .pending         (pending),
      .words_checked   (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // Watchdog: a hung handshake ends the run here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: rsp_ready drops in random bursts, separated by
   // ready stretches of varied length, some of them long. Once the run turns
   // calm, rsp_ready stays high.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (calm || ($urandom_range(0, 2) != 0)) begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(50, 200)) @(negedge clock);
            end else begin
               repeat ($urandom_range(1, 20)) @(negedge clock);
            end
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
      end
   end

   // Presents one word and holds it until the block takes it. Called and
   // returns at a falling edge.
   task automatic send_word(input logic [31:0] number);
      req_valid <= 1'b1;
      req_value <= number;
      do @(negedge clock); while (!req_taken);
   endtask

   // Drops valid for a random burst; the payload carries junk
   // meanwhile, which the block must not pick up.
   task automatic sender_gap();
      req_valid <= 1'b0;
      req_value <= $urandom;
      repeat ($urandom_range(1, 11)) @(negedge clock);
   endtask

   // Random numbers weighted so that short decimal forms, the 10-digit
   // range, values near the top of the word and neighbors of powers of ten
   // all show up often, besides plain uniform words.
   function automatic logic [31:0] pick_value();
      int          kind;
      int          width;
      logic [31:0] power;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            return $urandom;
         end
         3, 4, 5: begin
            width = $urandom_range(1, 9);
            power = 32'd1;
            for (int i = 0; i < width; i++) power = power * 32'd10;
            return $urandom_range(0, power - 32'd1);
         end
         6: begin
            return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         end
         7: begin
            width = $urandom_range(0, 9);
            power = 32'd1;
            for (int i = 0; i < width; i++) power = power * 32'd10;
            return power + $urandom_range(0, 20) - 32'd10;
         end
         default: begin
            return $urandom_range(32'd1000000000, 32'hFFFF_FFFF);
         end
      endcase
   endfunction

   initial begin
      logic [31:0] directed [$];
      bit          gappy;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      req_taken     = 1'b0;
      calm          = 1'b0;
      directed_sent = 0;
      random_sent   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words: zero, every single digit (whose check digit is the
      // first table row), digit-count boundaries, the largest and near
      // largest words, alternating bit patterns and a textbook example
      // (572 gives 4).
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                   32'd9, 32'd10, 32'd99, 32'd100, 32'd572, 32'd999999999,
                   32'd1000000000, 32'd2147483647, 32'd2147483648,
                   32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'd1234567890};
      // The first half runs back to back, the second half with gaps.
      foreach (directed[i]) begin
         send_word(directed[i]);
         directed_sent++;
         if (i > directed.size() / 2) sender_gap();
      end

      // Random part. The sender switches between bursty and gap-free
      // stretches every few dozen words; the last stretch is calm on both
      // sides.
      gappy = 1'b1;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         if ((n % 40) == 0) gappy = ($urandom_range(0, 2) != 0);
         send_word(pick_value());
         random_sent++;
         if (!calm && gappy && ($urandom_range(0, 2) == 0)) sender_gap();
      end
      req_valid <= 1'b0;
      req_value <= '0;

      // Every word is in; wait for the last results, then a little longer so
      // that a stray extra result would still be caught.
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d directed and %0d random numbers through the block, %0d results compared,",
               directed_sent, random_sent, words_checked);
      $display("with bursty sender gaps and receiver stalls, then a calm closing stretch.");
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
